/* rtl/core/dma_pattern_gen_and_crc8_check_top_defines.svh */
// assertion macros shared by the dma pattern generator / crc8 checker rtl
// no dependencies; included by modules that carry concurrent assertions
`ifndef DMA_PATTERN_GEN_AND_CRC8_CHECK_TOP_DEFINES_SVH
`define DMA_PATTERN_GEN_AND_CRC8_CHECK_TOP_DEFINES_SVH

// same-cycle implication, disabled while reset is asserted
`define DPG_ASSERT_NOW(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
		else $error("dpg assertion failed");

// next-cycle implication, disabled while reset is asserted
`define DPG_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
		else $error("dpg assertion failed");

`endif

/* rtl/core/dpg_pkg.sv */
// shared types, constants and the crc8 byte step for the dma data engine
// no dependencies; imported by every module of the block
package dpg_pkg;

	// pattern wraps after this many bytes
	localparam logic [7:0] PATTERN_MODULUS = 8'd251;
	// reflected crc-8 polynomial and start value
	localparam logic [7:0] CRC_REFL_TAPS = 8'hAB;
	localparam logic [7:0] CRC_INIT = 8'hFF;

	// transaction modes
	localparam logic MODE_START = 1'b0;
	localparam logic MODE_DATA  = 1'b1;

	// direction register values
	localparam logic DIR_WRITE = 1'b0;
	localparam logic DIR_READ  = 1'b1;

	// configuration register indexes
	localparam int unsigned CFG_IDX_W = 1;
	localparam logic [CFG_IDX_W-1:0] CFG_EXPECTED_CRC = 1'b0;
	localparam logic [CFG_IDX_W-1:0] CFG_DIRECTION    = 1'b1;

	typedef struct packed {
		logic       mode;
		logic [7:0] data_byte;
		logic       last;
	} in_item_t;

	typedef struct packed {
		logic [7:0] pattern_byte;
		logic       done_res;
		logic       status_error;
	} out_item_t;

	// fold one byte into the reflected crc, lsb first, one bit per step
	function automatic logic [7:0] crc8_update(input logic [7:0] crc, input logic [7:0] din);
		logic [7:0] c;
		c = crc ^ din;
		for (int b = 0; b < 8; b++) begin
			c = c[0] ? ((c >> 1) ^ CRC_REFL_TAPS) : (c >> 1);
		end
		return c;
	endfunction

endpackage

/* rtl/core/dpg_in_reg.sv */
// input register stage of the dma data engine
// depends on dpg_pkg for the input item type
module dpg_in_reg (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              cmd_valid,
	output logic              cmd_ready,
	input  dpg_pkg::in_item_t cmd,
	input  logic              adv,
	output logic              valid_s1,
	output dpg_pkg::in_item_t item_s1
);
	import dpg_pkg::*;

	// stage is free when empty or when its transaction moves on this cycle
	assign cmd_ready = !valid_s1 || adv;

	// occupancy flag
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (cmd_ready) begin
			valid_s1 <= cmd_valid;
		end
	end

	// payload capture, no reset needed
	always_ff @(posedge clk) begin
		if (cmd_ready && cmd_valid) begin
			item_s1 <= cmd;
		end
	end

endmodule

/* rtl/core/dpg_core.sv */
// configuration registers, crc / pattern state and result computation
// depends on dpg_pkg and the assertion macro header
`include "dma_pattern_gen_and_crc8_check_top_defines.svh"

module dpg_core (
	input  logic                                 clk,
	input  logic                                 arst_n,
	input  logic                                 cfg_we,
	input  logic [dpg_pkg::CFG_IDX_W-1:0]        cfg_index,
	input  logic [7:0]                           cfg_wdata,
	input  logic                                 adv,
	input  dpg_pkg::in_item_t                    item_s1,
	output dpg_pkg::out_item_t                   res
);
	import dpg_pkg::*;

	logic [7:0] expected_crc_q;
	logic       direction_q;
	logic [7:0] crc_q;
	logic [7:0] cnt_q;
	logic [7:0] cnt_eff;
	logic [7:0] crc_next;
	logic       is_start;
	logic       is_write;
	logic       is_read;

	// configuration writes
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			expected_crc_q <= 8'h00;
			direction_q    <= DIR_WRITE;
		end else if (cfg_we) begin
			case (cfg_index)
				CFG_EXPECTED_CRC: expected_crc_q <= cfg_wdata;
				CFG_DIRECTION:    direction_q    <= cfg_wdata[0];
				default: ;
			endcase
		end
	end

	// item decode
	assign is_start = (item_s1.mode == MODE_START);
	assign is_write = !is_start && (direction_q == DIR_WRITE);
	assign is_read  = !is_start && (direction_q == DIR_READ);

	// counter at or above the modulus restarts at zero
	assign cnt_eff  = (cnt_q >= PATTERN_MODULUS) ? 8'd0 : cnt_q;
	assign crc_next = crc8_update(crc_q, item_s1.data_byte);

	// engine state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			crc_q <= CRC_INIT;
			cnt_q <= 8'd0;
		end else if (adv) begin
			if (is_start) begin
				crc_q <= CRC_INIT;
				cnt_q <= 8'd0;
			end else if (is_write) begin
				cnt_q <= cnt_eff + 8'd1;
			end else begin
				crc_q <= crc_next;
			end
		end
	end

	// result of the transaction in stage 1; status sees the updated crc
	always_comb begin
		res.pattern_byte = is_write ? cnt_eff : 8'd0;
		res.done_res     = item_s1.last;
		if (!item_s1.last || direction_q == DIR_WRITE) begin
			res.status_error = 1'b0;
		end else if (is_start) begin
			res.status_error = (CRC_INIT != expected_crc_q);
		end else begin
			res.status_error = (crc_next != expected_crc_q);
		end
	end

	`DPG_ASSERT_NEXT(a_start_clears, clk, arst_n, adv && is_start,
		crc_q == CRC_INIT && cnt_q == 8'd0)
	`DPG_ASSERT_NOW(a_cnt_bound, clk, arst_n, 1'b1, cnt_q <= PATTERN_MODULUS)
	`DPG_ASSERT_NEXT(a_read_keeps_cnt, clk, arst_n, adv && is_read, $stable(cnt_q))
	`DPG_ASSERT_NEXT(a_write_keeps_crc, clk, arst_n, adv && is_write, $stable(crc_q))

endmodule

/* rtl/core/dpg_out_reg.sv */
// result register of the dma data engine
// depends on dpg_pkg for the result item type
module dpg_out_reg (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               load_valid,
	output logic               load_ready,
	input  dpg_pkg::out_item_t res,
	output logic               rsp_valid,
	input  logic               rsp_ready,
	output dpg_pkg::out_item_t rsp
);
	import dpg_pkg::*;

	// register can take a new result when empty or being drained
	assign load_ready = !rsp_valid || rsp_ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rsp_valid <= 1'b0;
		end else if (load_ready) begin
			rsp_valid <= load_valid;
		end
	end

	// result payload
	always_ff @(posedge clk) begin
		if (load_ready && load_valid) begin
			rsp <= res;
		end
	end

endmodule

/* rtl/core/dma_pattern_gen_and_crc8_check_top.sv */
// Data engine of a DMA test device: pattern generator and CRC-8 checker.
// Channels: cmd (valid/ready) carries mode, data_byte and last; rsp
// (valid/ready) returns pattern_byte, done_res and status_error, exactly
// one rsp transaction per cmd transaction, in order.
// Configuration: cfg_we/cfg_index/cfg_wdata writes expected_crc (index 0)
// and direction (index 1); write only while the engine is idle.
// Path: a command accepted into the input register passes the core logic
// into the result register and shows on rsp from there.
// Throughput: one transaction per cycle unless rsp stalls; the crc8 byte step
// and pattern counter both finish between the input and result registers.
// Stall: while rsp_ready is low a full result register holds, the input register
// fills and cmd_ready drops only when both are occupied.
// Reset: arst_n clears both registers' valid flags, sets the crc to 0xFF, the
// pattern counter to 0 and both configuration registers to 0.
// depends on dpg_pkg, dpg_in_reg, dpg_core and dpg_out_reg
module dma_pattern_gen_and_crc8_check_top (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          cfg_we,
	input  logic [dpg_pkg::CFG_IDX_W-1:0] cfg_index,
	input  logic [7:0]                    cfg_wdata,
	input  logic                          cmd_valid,
	output logic                          cmd_ready,
	input  dpg_pkg::in_item_t             cmd,
	output logic                          rsp_valid,
	input  logic                          rsp_ready,
	output dpg_pkg::out_item_t            rsp
);
	import dpg_pkg::*;

	logic      valid_s1;
	in_item_t  item_s1;
	out_item_t res;
	logic      load_ready;
	logic      adv;

	// stage 1 moves into the result register
	assign adv = valid_s1 && load_ready;

	dpg_in_reg u_in_reg (
		.clk       (clk),
		.arst_n    (arst_n),
		.cmd_valid (cmd_valid),
		.cmd_ready (cmd_ready),
		.cmd       (cmd),
		.adv       (adv),
		.valid_s1  (valid_s1),
		.item_s1   (item_s1)
	);

	dpg_core u_core (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_we    (cfg_we),
		.cfg_index (cfg_index),
		.cfg_wdata (cfg_wdata),
		.adv       (adv),
		.item_s1   (item_s1),
		.res       (res)
	);

	dpg_out_reg u_out_reg (
		.clk        (clk),
		.arst_n     (arst_n),
		.load_valid (valid_s1),
		.load_ready (load_ready),
		.res        (res),
		.rsp_valid  (rsp_valid),
		.rsp_ready  (rsp_ready),
		.rsp        (rsp)
	);

endmodule
